// ===== rtl/ser_pkg.sv =====
// shared types and constants for the rgb sobel edge block
`timescale 1ns / 1ps

package ser_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam logic [7:0]  EDGE_MAX  = 8'd255;
    localparam logic [21:0] SAT_LIMIT = 22'd65280;

    // configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef logic [23:0] pix_t;         // {red, green, blue}
    typedef logic [21:0] sq_t;          // gx^2 + gy^2
    typedef logic signed [2:0] coef_t;

    localparam coef_t KERN_X [9] = '{-3'sd1, 3'sd0, 3'sd1,
                                     -3'sd2, 3'sd0, 3'sd2,
                                     -3'sd1, 3'sd0, 3'sd1};
    localparam coef_t KERN_Y [9] = '{-3'sd1, -3'sd2, -3'sd1,
                                      3'sd0,  3'sd0,  3'sd0,
                                      3'sd1,  3'sd2,  3'sd1};

endpackage

// ===== rtl/ser_root.sv =====
// rounded, clamped integer square root for three channels, one bit a cycle
`timescale 1ns / 1ps

module ser_root
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  ser_pkg::sq_t     sq [3],
    output logic             done,
    output logic [7:0]       edge_val [3]
);

    logic             busy_reg;
    logic [3:0]       step_reg;
    ser_pkg::sq_t     sq_reg   [3];
    logic [7:0]       root_reg [3];
    logic [7:0]       edge_reg [3];
    logic             done_reg;

    logic [7:0]       trial    [3];
    logic [15:0]      trial_sq [3];
    logic [16:0]      round_lim [3];
    logic [7:0]       probe;

    always_comb
    begin
        probe = 8'h80 >> step_reg[2:0];
        for (int ch = 0; ch < 3; ch++)
        begin
            trial[ch]     = root_reg[ch] | probe;
            trial_sq[ch]  = 16'(trial[ch]) * 16'(trial[ch]);
            round_lim[ch] = 17'(16'(root_reg[ch]) * 16'(root_reg[ch])) + 17'(root_reg[ch]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == 4'd8)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            if (start)
            begin
                sq_reg[ch]   <= sq[ch];
                root_reg[ch] <= '0;
            end
            else if (busy_reg && step_reg != 4'd8)
            begin
                if (22'(trial_sq[ch]) <= sq_reg[ch])
                    root_reg[ch] <= trial[ch];
            end
            else if (busy_reg)
            begin
                // round up past the midpoint, saturate large sums
                if (sq_reg[ch] > ser_pkg::SAT_LIMIT)
                    edge_reg[ch] <= ser_pkg::EDGE_MAX;
                else if (22'(round_lim[ch]) < sq_reg[ch])
                    edge_reg[ch] <= root_reg[ch] + 8'd1;
                else
                    edge_reg[ch] <= root_reg[ch];
            end
        end
    end

    assign done     = done_reg;
    assign edge_val = edge_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("root done without a running pass");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg <= 4'd8)
        else $error("root step past final round");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && step_reg == 4'd0)
        else $error("root did not start");

endmodule

// ===== rtl/sobel_edge_rgb.sv =====
// top level: line store, window, gradient sequencing and output register
`timescale 1ns / 1ps

// RGB 3x3 Sobel edge block. Pixels of one frame arrive in raster order; one
// two-row line store (one entry per column holding the two previous rows)
// is read when a pixel is taken and written back the next cycle. Pixels
// outside the frame count as zero. Each pixel produces zero to four results
// (more than one only at the last row or column), each carrying the clamped
// rounded gradient magnitude for all three channels. A pixel with no result
// ends after its line read; each result passes gradient, squaring, an 8-step
// square-root unit and rounding plus any wait on m_tready. The user must
// write frame geometry via cfg only while idle; the block does not enforce it.

module sobel_edge_rgb
#(
    parameter int MAX_WIDTH = ser_pkg::MAX_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [12:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red_in, green_in, blue_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // red_edge, green_edge, blue_edge, out_row, out_col, zero pad
    output logic        m_tlast,   // last_of_run
    output logic        m_tuser    // end_of_frame
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 1);

    typedef enum logic [5:0]
    {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_GRAD = 6'b000100,
        S_SQ   = 6'b001000,
        S_ROOT = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [10:0]        fw_reg;
    logic [12:0]        fh_reg;
    logic [CW-1:0]      col_reg;
    logic [11:0]        row_reg;
    logic [CW-1:0]      cur_col_reg;
    logic [11:0]        cur_row_reg;
    ser_pkg::pix_t      pix_reg;
    ser_pkg::pix_t      win_reg [9];
    logic [3:0]         pend_reg;
    logic [1:0]         kind_reg;
    logic signed [11:0] gx_reg [3];
    logic signed [11:0] gy_reg [3];

    logic [47:0]        line_mem [MAX_WIDTH];
    logic [47:0]        line_rd_reg;

    logic               m_valid_reg;
    logic [47:0]        m_data_reg;
    logic               m_last_reg;
    logic               m_eof_reg;

    logic [CW-1:0]      w_eff;
    logic [12:0]        h_eff;
    logic [31:0]        w32;
    logic [CW-1:0]      c_adj;
    logic [12:0]        r_adj;
    logic               in_fire;
    logic [CW:0]        c_inc;
    logic [12:0]        r_inc;
    logic               c_first, c_last, r_last, r_top, r_second;
    ser_pkg::pix_t      up1, up2;
    logic [3:0]         flags;
    logic [3:0]         pend_left;
    logic signed [11:0] gx_c [3];
    logic signed [11:0] gy_c [3];
    ser_pkg::sq_t       sq_c [3];
    logic               root_done;
    logic [7:0]         root_edge [3];
    logic [11:0]        o_row;
    logic [31:0]        o_col32;

    // effective frame geometry
    always_comb
    begin
        if (fw_reg == 11'd0)
            w32 = 32'd1;
        else if (int'(fw_reg) > MAX_WIDTH)
            w32 = 32'(MAX_WIDTH);
        else
            w32 = 32'(fw_reg);
        w_eff = w32[CW-1:0];
        if (fh_reg == 13'd0)
            h_eff = 13'd1;
        else if (fh_reg > 13'(ser_pkg::MAX_HEIGHT))
            h_eff = 13'(ser_pkg::MAX_HEIGHT);
        else
            h_eff = fh_reg;
    end

    assign in_fire  = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    // position of the incoming pixel, after any geometry shrink
    always_comb
    begin
        if (col_reg >= w_eff)
        begin
            c_adj = '0;
            r_adj = 13'(row_reg) + 13'd1;
        end
        else
        begin
            c_adj = col_reg;
            r_adj = 13'(row_reg);
        end
        if (r_adj >= h_eff)
            r_adj = '0;
    end

    always_comb
    begin
        c_inc    = (CW+1)'(cur_col_reg) + (CW+1)'(1);
        r_inc    = 13'(cur_row_reg) + 13'd1;
        c_first  = (cur_col_reg == '0);
        c_last   = (c_inc == (CW+1)'(w_eff));
        r_last   = (r_inc == h_eff);
        r_top    = (cur_row_reg == '0);
        r_second = (cur_row_reg == 12'd1);
        up2      = (r_top || r_second) ? '0 : line_rd_reg[47:24];
        up1      = r_top ? '0 : line_rd_reg[23:0];
        flags[0] = !r_top && !c_first;
        flags[1] = !r_top && c_last;
        flags[2] = r_last && !c_first;
        flags[3] = r_last && c_last;
    end

    // results still pending once the current one is sent
    always_comb
    begin
        pend_left = pend_reg & ~(4'b0001 << kind_reg);
    end

    // gradients of the window, shifted down by kind[1] and right by kind[0]
    always_comb
    begin
        int ra;
        int cb;
        logic [7:0] v;
        for (int ch = 0; ch < 3; ch++)
        begin
            gx_c[ch] = '0;
            gy_c[ch] = '0;
            for (int a = 0; a < 3; a++)
            begin
                for (int b = 0; b < 3; b++)
                begin
                    ra = a + int'(kind_reg[1]);
                    cb = b + int'(kind_reg[0]);
                    if (ra <= 2 && cb <= 2)
                        v = win_reg[ra*3 + cb][(2-ch)*8 +: 8];
                    else
                        v = '0;
                    gx_c[ch] = gx_c[ch] + 12'(ser_pkg::KERN_X[a*3 + b]) * $signed({4'b0, v});
                    gy_c[ch] = gy_c[ch] + 12'(ser_pkg::KERN_Y[a*3 + b]) * $signed({4'b0, v});
                end
            end
        end
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
            sq_c[ch] = 22'(gx_reg[ch] * gx_reg[ch]) + 22'(gy_reg[ch] * gy_reg[ch]);
    end

    ser_root u_root
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_SQ),
        .sq       (sq_c),
        .done     (root_done),
        .edge_val (root_edge)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_fire) state_next = S_READ;
            S_READ: state_next = (flags != 4'b0000) ? S_GRAD : S_IDLE;
            S_GRAD: state_next = S_SQ;
            S_SQ:   state_next = S_ROOT;
            S_ROOT: if (root_done) state_next = S_OUT;
            S_OUT:
            begin
                if (m_tready)
                    state_next = (pend_left != 4'b0000) ? S_GRAD : S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            fw_reg      <= 11'd640;
            fh_reg      <= 13'd480;
            col_reg     <= '0;
            row_reg     <= '0;
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    ser_pkg::REG_FRAME_WIDTH:  fw_reg <= cfg_wdata[10:0];
                    ser_pkg::REG_FRAME_HEIGHT: fh_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            case (state_reg)
                S_READ:
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        win_reg[a*3]     <= c_first ? '0 : win_reg[a*3 + 1];
                        win_reg[a*3 + 1] <= c_first ? '0 : win_reg[a*3 + 2];
                    end
                    win_reg[2] <= up2;
                    win_reg[5] <= up1;
                    win_reg[8] <= pix_reg;
                    pend_reg   <= flags;
                    if (c_inc >= (CW+1)'(w_eff))
                    begin
                        col_reg <= '0;
                        row_reg <= (r_inc >= h_eff) ? '0 : r_inc[11:0];
                    end
                    else
                    begin
                        col_reg <= c_inc[CW-1:0];
                        row_reg <= cur_row_reg;
                    end
                end
                S_ROOT:
                begin
                    if (root_done)
                        m_valid_reg <= 1'b1;
                end
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        m_valid_reg <= 1'b0;
                        pend_reg    <= pend_left;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        o_row   = cur_row_reg - (kind_reg[1] ? 12'd0 : 12'd1);
        o_col32 = 32'(cur_col_reg) - (kind_reg[0] ? 32'd0 : 32'd1);
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cur_col_reg <= c_adj;
            cur_row_reg <= r_adj[11:0];
            pix_reg     <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
        end
        if (state_reg == S_GRAD)
        begin
            gx_reg <= gx_c;
            gy_reg <= gy_c;
        end
        if (state_reg == S_READ)
            kind_reg <= flags[0] ? 2'd0 : flags[1] ? 2'd1 : flags[2] ? 2'd2 : 2'd3;
        if (state_reg == S_OUT && m_tready)
        begin
            if (pend_left[0])
                kind_reg <= 2'd0;
            else if (pend_left[1])
                kind_reg <= 2'd1;
            else if (pend_left[2])
                kind_reg <= 2'd2;
            else
                kind_reg <= 2'd3;
        end
        if (state_reg == S_ROOT && root_done)
        begin
            m_data_reg <= {2'b00, o_col32[9:0], o_row,
                           root_edge[2], root_edge[1], root_edge[0]};
            m_last_reg <= (pend_left == 4'b0000);
            m_eof_reg  <= (kind_reg == 2'd3);
        end
    end

    // line store: read on accept, write back the shifted pair next cycle
    always_ff @(posedge clk)
    begin
        if (in_fire)
            line_rd_reg <= line_mem[c_adj[AW-1:0]];
        if (state_reg == S_READ)
            line_mem[cur_col_reg[AW-1:0]] <= {line_rd_reg[23:0], pix_reg};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_eof_reg;

    a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> state_reg == S_OUT)
        else $error("result shown outside output state");
    a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_READ)
        else $error("accepted pixel not followed by line read");
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_eof_reg |-> m_last_reg)
        else $error("end of frame not on last result of its pixel");
    a_read_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> state_reg == S_IDLE || state_reg == S_GRAD)
        else $error("bad exit from line read");

endmodule
